// ----- design/srfo_pkg.sv -----
// Package: shared types and constants of the section RVA to file offset translator.
package srfo_pkg;

  localparam int unsigned MAX_SECTIONS = 16;
  localparam int unsigned MEM_AW       = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned DATA_W       = 32;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_XLATE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    STAT_HEADER   = 3'd0,
    STAT_SECTION  = 3'd1,
    STAT_BEYOND   = 3'd2,
    STAT_MEMONLY  = 3'd3,
    STAT_UNMAPPED = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_SIZE   = 2'd0,
    CFG_FILE_SIZE     = 2'd1,
    CFG_SECTION_COUNT = 2'd2
  } cfg_idx_e;

  // One section table entry.
  typedef struct packed {
    logic [DATA_W-1:0] virt_addr;
    logic [DATA_W-1:0] virt_size;
    logic [DATA_W-1:0] raw_offset;
    logic [DATA_W-1:0] raw_size;
  } entry_t;

  typedef struct packed {
    op_e               operation;
    logic [IDX_W-1:0]  section_index;
    entry_t            sect;
    logic [DATA_W-1:0] rel_addr;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] header_size;
    logic [DATA_W-1:0] file_size;
    logic [CNT_W-1:0]  section_count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [MEM_AW-1:0] waddr;
    entry_t            wdata;
    logic              re;
    logic [MEM_AW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [DATA_W-1:0] file_offset;
  } res_t;

endpackage

// ----- design/srfo_if.sv -----
// Interfaces: input, result and configuration channels.
interface srfo_in_if;
  import srfo_pkg::*;
  logic              valid;
  logic              ready;
  op_e               operation;
  logic [IDX_W-1:0]  section_index;
  logic [DATA_W-1:0] sect_virt_addr;
  logic [DATA_W-1:0] sect_virt_size;
  logic [DATA_W-1:0] sect_raw_offset;
  logic [DATA_W-1:0] sect_raw_size;
  logic [DATA_W-1:0] rel_addr;

  modport source (output valid, operation, section_index, sect_virt_addr, sect_virt_size,
                  sect_raw_offset, sect_raw_size, rel_addr, input ready);
  modport sink   (input valid, operation, section_index, sect_virt_addr, sect_virt_size,
                  sect_raw_offset, sect_raw_size, rel_addr, output ready);
endinterface

interface srfo_out_if;
  import srfo_pkg::*;
  logic              valid;
  logic              ready;
  status_e           status;
  logic [DATA_W-1:0] file_offset;

  modport source (output valid, status, file_offset, input ready);
  modport sink   (input valid, status, file_offset, output ready);
endinterface

interface srfo_cfg_if;
  import srfo_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [DATA_W-1:0]    wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// ----- design/srfo_cfg_regs.sv -----
// Configuration registers: header size, file size, section count.
module srfo_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  srfo_cfg_if.sink          cfg_i,
  output srfo_pkg::cfg_t    cfg_o
);
  import srfo_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.reg_idx))
        CFG_HEADER_SIZE:   cfg_d.header_size   = cfg_i.wdata;
        CFG_FILE_SIZE:     cfg_d.file_size     = cfg_i.wdata;
        CFG_SECTION_COUNT: cfg_d.section_count = cfg_i.wdata[CNT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- design/srfo_table_ram.sv -----
// Section table memory: one write port, one read port, registered read data.
module srfo_table_ram (
  input  logic                clk_i,
  input  srfo_pkg::ram_req_t  req_i,
  output srfo_pkg::entry_t    rdata_o
);
  import srfo_pkg::*;

  entry_t mem_q [MAX_SECTIONS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/srfo_scan.sv -----
// Scan sequencer: stores write beats, walks the table for translate beats.
module srfo_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srfo_pkg::cfg_t      cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  srfo_pkg::item_t     item_i,
  output srfo_pkg::ram_req_t  ram_req_o,
  input  srfo_pkg::entry_t    ram_rdata_i,
  output srfo_pkg::res_t      res_o,
  input  logic                res_take_i
);
  import srfo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_SUM  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [DATA_W-1:0] rva_q, rva_d;
  logic [CNT_W-1:0]  n_q, n_d;
  logic [MEM_AW-1:0] ptr_q, ptr_d;
  logic [DATA_W-1:0] delta_q, delta_d;
  logic [DATA_W-1:0] roff_q, roff_d;
  status_e           stat_q, stat_d;
  logic [DATA_W-1:0] offs_q, offs_d;

  logic              accept;
  logic [CNT_W-1:0]  n_sat;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] delta;
  logic              covers;
  logic              last;
  logic [DATA_W:0]   sum;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign n_sat = (32'(cfg_i.section_count) > 32'(MAX_SECTIONS)) ?
                 CNT_W'(MAX_SECTIONS) : cfg_i.section_count;

  // Entry compare: borrow means rva below the section start.
  assign diff   = {1'b0, rva_q} - {1'b0, ram_rdata_i.virt_addr};
  assign delta  = diff[DATA_W-1:0];
  assign covers = !diff[DATA_W] &&
                  ((delta < ram_rdata_i.virt_size) || (delta < ram_rdata_i.raw_size));
  assign last   = (32'(ptr_q) + 32'd1) == 32'(n_q);
  assign sum    = {1'b0, roff_q} + {1'b0, delta_q};

  always_comb begin
    state_d = state_q;
    rva_d   = rva_q;
    n_d     = n_q;
    ptr_d   = ptr_q;
    delta_d = delta_q;
    roff_d  = roff_q;
    stat_d  = stat_q;
    offs_d  = offs_q;

    ram_req_o.we    = 1'b0;
    ram_req_o.waddr = MEM_AW'(item_i.section_index);
    ram_req_o.wdata = item_i.sect;
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.operation == OP_WRITE) begin
            ram_req_o.we = 32'(item_i.section_index) < 32'(MAX_SECTIONS);
          end else begin
            rva_d = item_i.rel_addr;
            n_d   = n_sat;
            ptr_d = '0;
            if (item_i.rel_addr < cfg_i.header_size) begin
              state_d = S_DONE;
              if (item_i.rel_addr < cfg_i.file_size) begin
                stat_d = STAT_HEADER;
                offs_d = item_i.rel_addr;
              end else begin
                stat_d = STAT_BEYOND;
                offs_d = '0;
              end
            end else if (n_sat == '0) begin
              state_d = S_DONE;
              stat_d  = STAT_UNMAPPED;
              offs_d  = '0;
            end else begin
              ram_req_o.re = 1'b1;
              state_d      = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (covers) begin
          if (delta >= ram_rdata_i.raw_size) begin
            state_d = S_DONE;
            stat_d  = STAT_MEMONLY;
            offs_d  = '0;
          end else begin
            delta_d = delta;
            roff_d  = ram_rdata_i.raw_offset;
            state_d = S_SUM;
          end
        end else if (last) begin
          state_d = S_DONE;
          stat_d  = STAT_UNMAPPED;
          offs_d  = '0;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = ptr_q + MEM_AW'(1);
          ptr_d           = ptr_q + MEM_AW'(1);
        end
      end
      S_SUM: begin
        state_d = S_DONE;
        if (sum < {1'b0, cfg_i.file_size}) begin
          stat_d = STAT_SECTION;
          offs_d = sum[DATA_W-1:0];
        end else begin
          stat_d = STAT_BEYOND;
          offs_d = '0;
        end
      end
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rva_q   <= rva_d;
    n_q     <= n_d;
    ptr_q   <= ptr_d;
    delta_q <= delta_d;
    roff_q  <= roff_d;
    stat_q  <= stat_d;
    offs_q  <= offs_d;
  end

  assign res_o.valid       = (state_q == S_DONE);
  assign res_o.status      = stat_q;
  assign res_o.file_offset = offs_q;

endmodule

// ----- design/section_rva_to_file_offset_core.sv -----
// Top level: section RVA to file offset translator core.
//
//   channel  dir  role                       beat carries
//   -------  ---  -------------------------  -------------------------------------
//   in_i     in   write / translate request  operation, section entry, rel_addr
//   out_o    out  translate result           status, file_offset
//   cfg_i    in   register write             reg_idx, wdata
//
// A write beat is stored in the section table in the cycle it is accepted;
// the next beat can follow in the very next cycle.
// A translate beat goes straight to the result on a header hit or empty table;
// else the table memory is walked one entry per cycle until an entry covers
// the address (a section hit then adds a sum step) or no entry matches.
// Reset clears control and config registers; table contents stay undefined.
// The result sits in an output register, so a stalled sink does not block
// the next write beat or the start of the next translate.
module section_rva_to_file_offset_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  srfo_in_if.sink    in_i,
  srfo_out_if.source out_o,
  srfo_cfg_if.sink   cfg_i
);
  import srfo_pkg::*;

  cfg_t     cfg;
  item_t    item;
  ram_req_t ram_req;
  entry_t   ram_rdata;
  res_t     res;
  logic     res_take;

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q;
  logic [DATA_W-1:0] out_offset_q;

  // Pack the input beat for the sequencer.
  assign item.operation       = in_i.operation;
  assign item.section_index   = in_i.section_index;
  assign item.sect.virt_addr  = in_i.sect_virt_addr;
  assign item.sect.virt_size  = in_i.sect_virt_size;
  assign item.sect.raw_offset = in_i.sect_raw_offset;
  assign item.sect.raw_size   = in_i.sect_raw_size;
  assign item.rel_addr        = in_i.rel_addr;

  srfo_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  srfo_table_ram u_table_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  srfo_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .item_i      (item),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  // Output register: loads when empty or being drained this cycle.
  assign res_take = res.valid && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (res_take) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_status_q <= res.status;
      out_offset_q <= res.file_offset;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_status_q;
  assign out_o.file_offset = out_offset_q;

`ifndef SYNTHESIS
  // A translate beat holds off input in the cycle after it is accepted.
  a_xlate_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.operation == OP_XLATE) |=> !in_i.ready)
    else $error("input taken right after a translate beat");

  // Only hits carry an offset.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status != STAT_HEADER && out_o.status != STAT_SECTION)
      |-> (out_o.file_offset == '0))
    else $error("non-hit result with nonzero offset");

  // A hit offset always lies inside the file.
  a_hit_in_file: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == STAT_HEADER || out_o.status == STAT_SECTION))
      |-> (out_o.file_offset < cfg.file_size))
    else $error("hit offset at or past file size");
`endif

endmodule
